// ----- sv/room_bus_poll_and_parse_assert.svh -----
// Assertion macros for the room bus poll and parse block.
// Used by the port checker; no other dependencies.
`ifndef ROOM_BUS_POLL_AND_PARSE_ASSERT_SVH
`define ROOM_BUS_POLL_AND_PARSE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define RBPP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("room bus check failed");

// Next-cycle implication, disabled while reset is high
`define RBPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("room bus check failed");

`endif

// ----- sv/rbpp_pkg.sv -----
// Shared types and constants for the room bus poll and parse block.
// No dependencies; imported by the interfaces, the frame builder and the top level.
package rbpp_pkg;

   localparam int POLL_IDS      = 10;
   localparam int PAGE_COUNT    = 6;
   localparam int ROW_BYTES     = 4;
   localparam int STATUS_ROOMS  = 8;

   localparam logic [3:0] LAST_POLL_ID   = 4'(POLL_IDS - 1);
   localparam logic [3:0] LAST_PLAIN_ID  = 4'd6;
   localparam logic [3:0] BLANK_ID_LO    = 4'd7;
   localparam logic [3:0] BLANK_ID_HI    = 4'd8;
   localparam logic [7:0] POLL_ID_SHIFT  = 8'd2;
   localparam logic [2:0] LAST_PAGE      = 3'(PAGE_COUNT - 1);
   localparam logic [7:0] DIFF_BIAS      = 8'd100;
   localparam logic [3:0] LAST_STATUS_ID = 4'(STATUS_ROOMS);

   localparam logic [PAGE_COUNT-1:0][ROW_BYTES-1:0][7:0] PAGE_ROWS = '{
      '{8'h07, 8'h07, 8'h06, 8'h06},
      '{8'h05, 8'h05, 8'h04, 8'h04},
      '{8'h03, 8'h03, 8'h02, 8'h02},
      '{8'h01, 8'h01, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'hC8, 8'h06},
      '{8'h45, 8'h30, 8'h11, 8'hE0}
   };

   typedef enum logic {
      CMD_DECODE = 1'b0,
      CMD_POLL   = 1'b1
   } cmd_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte0;
      logic [7:0] rx_byte1;
      logic [7:0] rx_byte2;
      logic [7:0] rx_byte3;
   } req_payload_type;

   typedef struct packed {
      logic        accepted;
      logic [3:0]  room_id;
      logic [2:0]  op_mode;
      logic [5:0]  timer_value;
      logic        run_on;
      logic [7:0]  cur_temp;
      logic [7:0]  set_temp;
      logic [7:0]  temp_diff;
      logic        warmer;
      logic [7:0]  room_status;
      logic [31:0] tx_low;
      logic [31:0] tx_high;
   } rsp_payload_type;

endpackage

// ----- sv/rbpp_req_if.sv -----
// Request channel: valid/ready handshake carrying one request payload.
// Depends on rbpp_pkg for the payload type.
interface rbpp_req_if
   import rbpp_pkg::*;
   ;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/rbpp_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one response payload.
// Depends on rbpp_pkg for the payload type.
interface rbpp_rsp_if
   import rbpp_pkg::*;
   ;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/rbpp_poll_frame.sv -----
// Poll frame builder: id remap, page row lookup, checksum and counter advance.
// Depends on rbpp_pkg for the page table and counter limits.
module rbpp_poll_frame
   import rbpp_pkg::*;
(
   input  logic [3:0]  poll_index,
   input  logic [2:0]  page_index,
   input  logic [7:0]  status_bits,
   output logic [31:0] tx_low,
   output logic [31:0] tx_high,
   output logic [3:0]  poll_next,
   output logic [2:0]  page_next
);

   logic [3:0] poll_eff;
   logic [2:0] page_eff;
   logic [7:0] byte0;
   logic [7:0] byte1;
   logic [7:0] byte2;
   logic [ROW_BYTES-1:0][7:0] row;
   logic [7:0] checksum;

   // out-of-cycle counters act as zero
   assign poll_eff = (poll_index > LAST_POLL_ID) ? 4'd0 : poll_index;
   assign page_eff = (page_index > LAST_PAGE) ? 3'd0 : page_index;

   // ids above six skip two codes on the wire; ids seven and eight hide status
   assign byte0 = (poll_eff <= LAST_PLAIN_ID) ? {4'd0, poll_eff}
                                              : {4'd0, poll_eff} + POLL_ID_SHIFT;
   assign byte1 = {5'd0, page_eff};
   assign byte2 = (poll_eff == BLANK_ID_LO || poll_eff == BLANK_ID_HI) ? 8'd0
                                                                        : status_bits;
   assign row   = PAGE_ROWS[page_eff];

   // 8-bit wrapping sum of bytes 0..6
   assign checksum = byte0 + byte1 + byte2 + row[0] + row[1] + row[2] + row[3];

   assign tx_low  = {row[0], byte2, byte1, byte0};
   assign tx_high = {checksum, row[3], row[2], row[1]};

   // advance both rotations
   assign poll_next = (poll_eff == LAST_POLL_ID) ? 4'd0 : poll_eff + 4'd1;
   assign page_next = (page_eff == LAST_PAGE) ? 3'd0 : page_eff + 3'd1;

endmodule

// ----- sv/room_bus_poll_and_parse.sv -----
// Room bus poll and parse: top level with decode path, state and output register.
// Depends on rbpp_pkg, rbpp_req_if, rbpp_rsp_if and rbpp_poll_frame.
//
// Usage:
//   req_bus carries one request per handshake: cmd 0 decodes the four received
//   bytes of a room frame, cmd 1 asks for the next 8-byte poll frame.
//   rsp_bus returns exactly one response per request, in order.
//   Responses are registered: a request taken at an edge is shown on rsp_bus
//   in the next cycle. Throughput is one request per cycle unless rsp_bus
//   stalls; the only storage in the path is the response register, and the
//   poll/page counters and the room status byte update at the same edge the
//   request is taken. A new request is taken while the response register is
//   empty or is being drained in that cycle, so a stalled receiver holds the
//   response stable and blocks req_bus until it is taken.
//   Synchronous reset clears the response valid, both poll counters and the
//   status byte; nothing else needs reset.
module room_bus_poll_and_parse
   import rbpp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rbpp_req_if.sink   req_bus,
   rbpp_rsp_if.source rsp_bus
);

   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic [3:0]      poll_index_ff;
   logic [3:0]      poll_index_in;
   logic [2:0]      page_index_ff;
   logic [2:0]      page_index_in;
   logic [7:0]      status_bits_ff;
   logic [7:0]      status_bits_in;

   logic            take;
   req_payload_type rq;
   logic [3:0]      id;
   logic [7:0]      cur;
   logic [7:0]      status_set;
   logic [31:0]     frame_low;
   logic [31:0]     frame_high;
   logic [3:0]      poll_next;
   logic [2:0]      page_next;

   // handshake: accept when the response slot is free or draining
   assign req_bus.ready   = !rsp_valid_ff || rsp_bus.ready;
   assign take            = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;
   assign rq              = req_bus.payload;

   rbpp_poll_frame u_frame (
      .poll_index  (poll_index_ff),
      .page_index  (page_index_ff),
      .status_bits (status_bits_ff),
      .tx_low      (frame_low),
      .tx_high     (frame_high),
      .poll_next   (poll_next),
      .page_next   (page_next)
   );

   // decode path and next state
   assign id  = rq.rx_byte0[3:0];
   assign cur = {rq.rx_byte2[6:0], rq.rx_byte2[7]};
   assign status_set = (id != 4'd0 && id <= LAST_STATUS_ID)
                       ? (8'd1 << (id - 4'd1)) : 8'd0;

   always_comb begin
      rsp_data_in    = '0;
      poll_index_in  = poll_index_ff;
      page_index_in  = page_index_ff;
      status_bits_in = status_bits_ff;
      case (cmd_type'(rq.cmd))
         CMD_DECODE: begin
            status_bits_in = status_bits_ff | status_set;
            if (id != 4'd0) begin
               rsp_data_in.accepted     = 1'b1;
               rsp_data_in.room_id      = id;
               rsp_data_in.op_mode      = rq.rx_byte0[6:4];
               rsp_data_in.timer_value  = rq.rx_byte1[5:0];
               rsp_data_in.run_on       = rq.rx_byte1[7];
               rsp_data_in.cur_temp     = cur;
               rsp_data_in.set_temp     = rq.rx_byte3;
               rsp_data_in.temp_diff    = DIFF_BIAS + rq.rx_byte3 - cur;
               rsp_data_in.warmer       = rq.rx_byte3 > cur;
            end
            rsp_data_in.room_status = status_bits_in;
         end
         CMD_POLL: begin
            rsp_data_in.room_status = status_bits_ff;
            rsp_data_in.tx_low      = frame_low;
            rsp_data_in.tx_high     = frame_high;
            poll_index_in           = poll_next;
            page_index_in           = page_next;
         end
         default: begin
            rsp_data_in.room_status = status_bits_ff;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         poll_index_ff  <= 4'd0;
         page_index_ff  <= 3'd0;
         status_bits_ff <= 8'd0;
      end else begin
         if (take) begin
            rsp_valid_ff   <= 1'b1;
            poll_index_ff  <= poll_index_in;
            page_index_ff  <= page_index_in;
            status_bits_ff <= status_bits_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- sv/rbpp_checker.sv -----
// Port-level checker for room_bus_poll_and_parse, bound to the top level.
// Depends on rbpp_pkg and room_bus_poll_and_parse_assert.svh.
`include "room_bus_poll_and_parse_assert.svh"

module rbpp_checker
   import rbpp_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   logic [7:0] frame_sum;
   logic       rsp_stall;
   logic       req_take;
   logic       decode_clean;
   logic       sum_ok;

   // checksum over bytes 0..6 of the poll frame
   assign frame_sum = rsp_payload.tx_low[7:0] + rsp_payload.tx_low[15:8]
                    + rsp_payload.tx_low[23:16] + rsp_payload.tx_low[31:24]
                    + rsp_payload.tx_high[7:0] + rsp_payload.tx_high[15:8]
                    + rsp_payload.tx_high[23:16];

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign req_take     = req_valid && req_ready;
   assign decode_clean = rsp_payload.tx_low == 32'd0 && rsp_payload.tx_high == 32'd0
                         && rsp_payload.room_id != 4'd0;
   assign sum_ok       = rsp_payload.tx_high[31:24] == frame_sum;

   // a stalled response holds
   `RBPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // every taken request shows a response in the next cycle
   `RBPP_ASSERT_NEXT(a_one_cycle, clock, reset, req_take, rsp_valid)

   // a decoded frame carries no poll bytes and a nonzero room id
   `RBPP_ASSERT_SAME(a_decode_clean, clock, reset, rsp_valid && rsp_payload.accepted, decode_clean)

   // the poll frame checksum matches its bytes
   `RBPP_ASSERT_SAME(a_checksum, clock, reset, rsp_valid, sum_ok)

endmodule

bind room_bus_poll_and_parse rbpp_checker u_rbpp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

// ----- sim/tb_room_bus_check.sv -----
// Checker for the room bus poll and parse block: watches both channels,
// predicts each response and compares it field by field.
// Depends on rbpp_pkg, rbpp_req_if and rbpp_rsp_if.
module tb_room_bus_check
   import rbpp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rbpp_req_if  req_mon,
   rbpp_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Fixed page rows sent in bytes 3..6 of the poll frame, byte 3 first
   localparam logic [7:0] POLL_PAGE [PAGE_COUNT][ROW_BYTES] = '{
      '{8'hE0, 8'h11, 8'h30, 8'h45},
      '{8'h06, 8'hC8, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h01, 8'h01},
      '{8'h02, 8'h02, 8'h03, 8'h03},
      '{8'h04, 8'h04, 8'h05, 8'h05},
      '{8'h06, 8'h06, 8'h07, 8'h07}
   };

   // Predicted block state
   logic [3:0] poll_id;
   logic [2:0] page;
   logic [7:0] room_bits;

   rsp_payload_type replies_due[$];

   // Response to one request; advances the predicted state
   function automatic rsp_payload_type parse_or_poll(input req_payload_type rq);
      rsp_payload_type r;
      logic [3:0]      id;
      logic [3:0]      pi;
      logic [2:0]      pg;
      logic [7:0]      cur;
      logic [7:0]      sum;
      logic [7:0]      frame [8];
      r = '0;
      if (rq.cmd == CMD_DECODE) begin
         id = rq.rx_byte0[3:0];
         // room id zero: frame dropped, only the status byte is reported
         if (id != 4'd0) begin
            cur = {rq.rx_byte2[6:0], rq.rx_byte2[7]};
            if (id <= LAST_STATUS_ID)
               room_bits[id - 4'd1] = 1'b1;
            r.accepted     = 1'b1;
            r.room_id      = id;
            r.op_mode      = rq.rx_byte0[6:4];
            r.timer_value  = rq.rx_byte1[5:0];
            r.run_on       = rq.rx_byte1[7];
            r.cur_temp     = cur;
            r.set_temp     = rq.rx_byte3;
            r.temp_diff    = DIFF_BIAS + rq.rx_byte3 - cur;
            r.warmer       = (rq.rx_byte3 > cur);
         end
      end else begin
         // out-of-range counters restart the cycle
         pi = (poll_id < POLL_IDS) ? poll_id : 4'd0;
         pg = (page < PAGE_COUNT) ? page : 3'd0;
         frame[0] = (pi <= LAST_PLAIN_ID) ? 8'(pi) : 8'(pi) + POLL_ID_SHIFT;
         frame[1] = 8'(pg);
         frame[2] = (pi == BLANK_ID_LO || pi == BLANK_ID_HI) ? 8'h00 : room_bits;
         for (int i = 0; i < ROW_BYTES; i++)
            frame[3 + i] = POLL_PAGE[pg][i];
         sum = 8'h00;
         for (int i = 0; i < 7; i++)
            sum = sum + frame[i];
         frame[7] = sum;
         r.tx_low  = {frame[3], frame[2], frame[1], frame[0]};
         r.tx_high = {frame[7], frame[6], frame[5], frame[4]};
         poll_id = (pi == LAST_POLL_ID) ? 4'd0 : pi + 4'd1;
         page    = (pg == LAST_PAGE) ? 3'd0 : pg + 3'd1;
      end
      r.room_status = room_bits;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   // Compare responses first, then record the request taken at this edge
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         poll_id   = 4'd0;
         page      = 3'd0;
         room_bits = 8'h00;
         replies_due.delete();
         pending   = 0;
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got = rsp_mon.payload;
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %h", $time, got);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               check_field("accepted", want.accepted, got.accepted);
               check_field("room_id", want.room_id, got.room_id);
               check_field("op_mode", want.op_mode, got.op_mode);
               check_field("timer_value", want.timer_value, got.timer_value);
               check_field("run_on", want.run_on, got.run_on);
               check_field("cur_temp", want.cur_temp, got.cur_temp);
               check_field("set_temp", want.set_temp, got.set_temp);
               check_field("temp_diff", want.temp_diff, got.temp_diff);
               check_field("warmer", want.warmer, got.warmer);
               check_field("room_status", want.room_status, got.room_status);
               check_field("tx_low", want.tx_low, got.tx_low);
               check_field("tx_high", want.tx_high, got.tx_high);
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            replies_due.push_back(parse_or_poll(req_mon.payload));
         pending = replies_due.size();
      end
   end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the room bus poll and parse block: clock, reset,
// request stimulus with random idling, response stalls and the verdict.
// Depends on rbpp_pkg, both channel interfaces, the block and tb_room_bus_check.
module tb_top
   import rbpp_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_pct  = 8;
   int   stall_pct = 77;
   int   fail_count;
   int   pending;

   rbpp_req_if req_bus ();
   rbpp_rsp_if rsp_bus ();

   room_bus_poll_and_parse uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tb_room_bus_check bus_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver stalls at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Hard stop for a hung block
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Drive one request, with a random gap ahead of it; returns at a falling edge
   task automatic send_request(input cmd_type cmd, input logic [7:0] b0,
                               input logic [7:0] b1, input logic [7:0] b2,
                               input logic [7:0] b3);
      req_payload_type p;
      p.cmd      = cmd;
      p.rx_byte0 = b0;
      p.rx_byte1 = b1;
      p.rx_byte2 = b2;
      p.rx_byte3 = b3;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= p;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   initial begin
      logic [7:0] b2;
      logic [7:0] b3;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: poll from reset, dropped frames, every status room, ids above 8
      send_request(CMD_POLL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_request(CMD_DECODE, 8'hF0, 8'hFF, 8'hFF, 8'hFF);
      send_request(CMD_DECODE, 8'h00, 8'h00, 8'h00, 8'h00);
      send_request(CMD_DECODE, 8'h71, 8'hBF, 8'h80, 8'h01); // equal temps
      send_request(CMD_DECODE, 8'h02, 8'h40, 8'h00, 8'hFF); // set above current
      send_request(CMD_DECODE, 8'h83, 8'h80, 8'hFF, 8'h00); // set below current
      send_request(CMD_DECODE, 8'h14, 8'h2A, 8'h7F, 8'hFE);
      send_request(CMD_DECODE, 8'hA5, 8'h95, 8'h01, 8'h02);
      send_request(CMD_DECODE, 8'h36, 8'hC0, 8'h32, 8'h64);
      send_request(CMD_DECODE, 8'hC7, 8'h3F, 8'hFE, 8'hFF);
      send_request(CMD_DECODE, 8'h48, 8'hFF, 8'h55, 8'hAA);
      send_request(CMD_DECODE, 8'h09, 8'h81, 8'h10, 8'h20);
      send_request(CMD_DECODE, 8'hFF, 8'h7E, 8'hAA, 8'h55);
      // Poll ids 1..9 and back to 0, pages wrap twice
      repeat (11)
         send_request(CMD_POLL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

      // Random: three idling phases
      for (int n = 0; n < 1900; n++) begin
         if (n == 633) begin
            idle_pct  = 77;
            stall_pct = 8;
         end else if (n == 1266) begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         if ($urandom_range(99) < 30) begin
            send_request(CMD_POLL, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
         end else begin
            b2 = 8'($urandom);
            b3 = 8'($urandom);
            // sometimes make set equal to the rotated current temperature
            if ($urandom_range(9) == 0)
               b3 = {b2[6:0], b2[7]};
            send_request(CMD_DECODE, 8'($urandom), 8'($urandom), b2, b3);
         end
      end
      req_bus.valid <= 1'b0;

      // Drain, then wait for stray responses
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
